/* rtl/plb_pkg.sv */
// shared constants for the positional list buffer: field widths, default depth, mode and status codes
// no dependencies
`default_nettype none

package plb_pkg;

   // field widths
   localparam int MODE_W = 3;
   localparam int POS_W  = 7;
   localparam int VAL_W  = 7;
   localparam int STAT_W = 2;

   // default list depth
   localparam int DEPTH_DEF = 64;

   // request modes
   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_DELETE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FIND   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

   // response status codes
   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_BAD_POS = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;
   localparam logic [STAT_W-1:0] STAT_NONE    = 2'd3;

endpackage

`default_nettype wire

/* rtl/plb_mem.sv */
// element store of the positional list buffer: one write port, one read port,
// registered read data; uses plb_pkg for the value width
`default_nettype none

module plb_mem #(
   parameter int DEPTH = plb_pkg::DEPTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire                       clock,
   input  wire                       wr_en,
   input  wire  [AW-1:0]             wr_addr,
   input  wire  [plb_pkg::VAL_W-1:0] wr_data,
   input  wire  [AW-1:0]             rd_addr,
   output logic [plb_pkg::VAL_W-1:0] rd_data
);

   logic [plb_pkg::VAL_W-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/positional_list_buffer.sv */
// top level of the positional list buffer: command decode, shift and scan sequencer
// around the element store; uses plb_pkg and plb_mem
`default_nettype none

// Ordered list of up to DEPTH 7-bit values. A command is taken when start is high
// and busy is low; busy stays high until the command's last result has been put out.
// Results appear for one cycle each with rsp_strobe and cannot be held off.
// All list traffic goes through one store with one read and one write port, so
// moved or scanned elements pass through it one at a time. An insert shifts the
// entries from the tail down to the position, then writes the new value. A delete
// pulls the entries behind the run forward. Find scans from the head and stops at
// the first match. Read out puts out one beat per cycle. Clear, a zero-length
// delete, a find or read out on an empty list and a rejected command answer with
// busy staying low.
// The store needs no clearing pass after reset: only entries below the count are read.
module positional_list_buffer #(
   parameter int DEPTH = plb_pkg::DEPTH_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   output logic                       busy,
   input  wire  [plb_pkg::MODE_W-1:0] req_mode,
   input  wire  [plb_pkg::POS_W-1:0]  req_position,
   input  wire  [plb_pkg::POS_W-1:0]  req_run_length,
   input  wire  [plb_pkg::VAL_W-1:0]  req_item_value,
   output logic                       rsp_strobe,
   output logic [plb_pkg::STAT_W-1:0] rsp_status,
   output logic [plb_pkg::POS_W-1:0]  rsp_found_position,
   output logic [plb_pkg::VAL_W-1:0]  rsp_read_value,
   output logic [plb_pkg::POS_W-1:0]  rsp_element_count,
   output logic                       rsp_last
);

   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = plb_pkg::POS_W;
   localparam int SW    = PW + 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_PUT  = 2'd2;

   logic [1:0]                 state_ff, state_in;
   logic [PW-1:0]              count_ff, count_in;
   logic [plb_pkg::MODE_W-1:0] op_ff, op_in;
   logic [plb_pkg::VAL_W-1:0]  val_ff, val_in;
   logic [PW-1:0]              run_ff, run_in;
   logic [AW-1:0]              put_addr_ff, put_addr_in;
   logic [AW-1:0]              rd_ptr_ff, rd_ptr_in;
   logic [PW-1:0]              left_ff, left_in;
   logic                       ret_vld_ff, ret_vld_in;
   logic [AW-1:0]              ret_idx_ff, ret_idx_in;

   logic                       strobe_ff, strobe_in;
   logic [plb_pkg::STAT_W-1:0] status_ff, status_in;
   logic [PW-1:0]              found_ff, found_in;
   logic [plb_pkg::VAL_W-1:0]  value_ff, value_in;
   logic                       last_ff, last_in;

   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [plb_pkg::VAL_W-1:0]  wr_data;
   logic [plb_pkg::VAL_W-1:0]  rd_data;

   logic [SW-1:0] pos_w, run_w, cnt_w, del_end, ret_w;
   logic          ins_bad, is_full, del_bad, done_now;

   // reads and writes never hit the same entry in one cycle: an insert writes one
   // above the entry whose data it is moving while reading the one below that, a delete
   // writes at least one below the entry it is reading
   plb_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   // range checks on the incoming command
   assign pos_w   = {1'b0, req_position};
   assign run_w   = {1'b0, req_run_length};
   assign cnt_w   = {1'b0, count_ff};
   assign del_end = pos_w - SW'(1) + run_w;
   assign ins_bad = (req_position == '0) || (pos_w > cnt_w + SW'(1));
   assign is_full = (cnt_w == SW'(DEPTH));
   assign del_bad = (req_position == '0) || (pos_w > cnt_w) || (del_end > cnt_w);
   assign ret_w   = {{(SW-AW){1'b0}}, ret_idx_ff};

   // sequencer
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      op_in       = op_ff;
      val_in      = val_ff;
      run_in      = run_ff;
      put_addr_in = put_addr_ff;
      rd_ptr_in   = rd_ptr_ff;
      left_in     = left_ff;
      ret_vld_in  = 1'b0;
      ret_idx_in  = ret_idx_ff;
      strobe_in   = 1'b0;
      status_in   = plb_pkg::STAT_OK;
      found_in    = '0;
      value_in    = '0;
      last_in     = 1'b1;
      wr_en       = 1'b0;
      wr_addr     = put_addr_ff;
      wr_data     = val_ff;
      done_now    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in       = req_mode;
               val_in      = req_item_value;
               run_in      = req_run_length;
               put_addr_in = AW'(pos_w - SW'(1));
               unique case (req_mode) inside
                  plb_pkg::MODE_INSERT: begin
                     if (ins_bad) begin
                        strobe_in = 1'b1;
                        status_in = plb_pkg::STAT_BAD_POS;
                     end else if (is_full) begin
                        strobe_in = 1'b1;
                        status_in = plb_pkg::STAT_FULL;
                     end else begin
                        // shift entries from the tail down to the position
                        rd_ptr_in = AW'(cnt_w - SW'(1));
                        left_in   = PW'(cnt_w - pos_w + SW'(1));
                        state_in  = S_RUN;
                     end
                  end
                  plb_pkg::MODE_DELETE: begin
                     if (del_bad) begin
                        strobe_in = 1'b1;
                        status_in = plb_pkg::STAT_BAD_POS;
                     end else if (req_run_length == '0) begin
                        strobe_in = 1'b1;
                     end else begin
                        // pull the entries behind the run forward
                        rd_ptr_in = AW'(del_end);
                        left_in   = PW'(cnt_w - del_end);
                        state_in  = S_RUN;
                     end
                  end
                  plb_pkg::MODE_FIND, plb_pkg::MODE_READ: begin
                     if (count_ff == '0) begin
                        strobe_in = 1'b1;
                        status_in = plb_pkg::STAT_NONE;
                     end else begin
                        rd_ptr_in = '0;
                        left_in   = count_ff;
                        state_in  = S_RUN;
                     end
                  end
                  plb_pkg::MODE_CLEAR: begin
                     count_in  = '0;
                     strobe_in = 1'b1;
                  end
                  default: begin
                     strobe_in = 1'b1;
                     status_in = plb_pkg::STAT_BAD_POS;
                  end
               endcase
            end
         end

         S_RUN: begin
            // handle the entry read in the previous cycle
            if (ret_vld_ff) begin
               case (op_ff)
                  plb_pkg::MODE_INSERT: begin
                     wr_en   = 1'b1;
                     wr_addr = ret_idx_ff + AW'(1);
                     wr_data = rd_data;
                  end
                  plb_pkg::MODE_DELETE: begin
                     wr_en   = 1'b1;
                     wr_addr = AW'(ret_w - {1'b0, run_ff});
                     wr_data = rd_data;
                  end
                  plb_pkg::MODE_FIND: begin
                     if (rd_data == val_ff) begin
                        done_now  = 1'b1;
                        strobe_in = 1'b1;
                        found_in  = PW'(ret_w + SW'(1));
                        state_in  = S_IDLE;
                     end
                  end
                  plb_pkg::MODE_READ: begin
                     strobe_in = 1'b1;
                     value_in  = rd_data;
                     last_in   = (PW'(ret_w + SW'(1)) == count_ff);
                     if (last_in) begin
                        done_now = 1'b1;
                        state_in = S_IDLE;
                     end
                  end
                  default: begin
                     done_now = 1'b1;
                     state_in = S_IDLE;
                  end
               endcase
            end

            // issue the next read
            if (!done_now && left_ff != '0) begin
               ret_vld_in = 1'b1;
               ret_idx_in = rd_ptr_ff;
               left_in    = left_ff - PW'(1);
               rd_ptr_in  = (op_ff == plb_pkg::MODE_INSERT) ? rd_ptr_ff - AW'(1)
                                                            : rd_ptr_ff + AW'(1);
            end

            // all reads handled
            if (!done_now && left_ff == '0 && !ret_vld_ff) begin
               case (op_ff)
                  plb_pkg::MODE_INSERT: begin
                     state_in = S_PUT;
                  end
                  plb_pkg::MODE_DELETE: begin
                     count_in  = count_ff - run_ff;
                     strobe_in = 1'b1;
                     state_in  = S_IDLE;
                  end
                  plb_pkg::MODE_FIND: begin
                     strobe_in = 1'b1;
                     status_in = plb_pkg::STAT_NONE;
                     state_in  = S_IDLE;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_PUT: begin
            // new value into the opened slot
            wr_en     = 1'b1;
            wr_addr   = put_addr_ff;
            wr_data   = val_ff;
            count_in  = count_ff + PW'(1);
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         left_ff    <= '0;
         ret_vld_ff <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         left_ff    <= left_in;
         ret_vld_ff <= ret_vld_in;
         strobe_ff  <= strobe_in;
      end
   end

   // command and result payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      val_ff      <= val_in;
      run_ff      <= run_in;
      put_addr_ff <= put_addr_in;
      rd_ptr_ff   <= rd_ptr_in;
      ret_idx_ff  <= ret_idx_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
      value_ff    <= value_in;
      last_ff     <= last_in;
   end

   // outputs
   assign busy               = (state_ff != S_IDLE);
   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_found_position = found_ff;
   assign rsp_read_value     = value_ff;
   assign rsp_element_count  = count_ff;
   assign rsp_last           = last_ff;

endmodule

`default_nettype wire

/* tb/list_checker.sv */
// checker for the positional list buffer: watches command and result beats, predicts
// the list contents and compares every result beat; depends on plb_pkg
`timescale 1ns / 100ps

module list_checker #(
   parameter int DEPTH = plb_pkg::DEPTH_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   input  wire                        busy,
   input  wire  [plb_pkg::MODE_W-1:0] req_mode,
   input  wire  [plb_pkg::POS_W-1:0]  req_position,
   input  wire  [plb_pkg::POS_W-1:0]  req_run_length,
   input  wire  [plb_pkg::VAL_W-1:0]  req_item_value,
   input  wire                        rsp_strobe,
   input  wire  [plb_pkg::STAT_W-1:0] rsp_status,
   input  wire  [plb_pkg::POS_W-1:0]  rsp_found_position,
   input  wire  [plb_pkg::VAL_W-1:0]  rsp_read_value,
   input  wire  [plb_pkg::POS_W-1:0]  rsp_element_count,
   input  wire                        rsp_last,
   output int                         fail_count,
   output int                         outstanding,
   output int                         held,
   output int                         beats_checked,
   output int                         full_seen
);
   import plb_pkg::*;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [POS_W-1:0]  found;
      logic [VAL_W-1:0]  value;
      logic [POS_W-1:0]  count;
      logic              last;
   } beat_type;

   // predicted list contents and the result beats still owed by the block
   logic [VAL_W-1:0] list_mem [DEPTH];
   beat_type         owed_beats[$];
   beat_type         got_beat;
   beat_type         want_beat;

   initial begin
      fail_count    = 0;
      outstanding   = 0;
      held          = 0;
      beats_checked = 0;
      full_seen     = 0;
   end

   // queue one expected beat, element count taken after the operation
   task automatic owe(input logic [STAT_W-1:0] st, input int fnd, input logic [VAL_W-1:0] v,
                      input logic lst);
      beat_type b;
      b.status = st;
      b.found  = POS_W'(fnd);
      b.value  = v;
      b.count  = POS_W'(held);
      b.last   = lst;
      owed_beats.push_back(b);
   endtask

   // apply one accepted command to the predicted list and queue its result beats
   task automatic predict_list_op(input logic [MODE_W-1:0] m, input int pos, input int run,
                                  input logic [VAL_W-1:0] v);
      int i;
      int hit;
      case (m)
         MODE_INSERT: begin
            if (pos == 0 || pos > held + 1) begin
               owe(STAT_BAD_POS, 0, '0, 1'b1);
            end else if (held >= DEPTH) begin
               full_seen++;
               owe(STAT_FULL, 0, '0, 1'b1);
            end else begin
               for (i = held; i >= pos; i--) list_mem[i] = list_mem[i-1];
               list_mem[pos-1] = v;
               held++;
               owe(STAT_OK, 0, '0, 1'b1);
            end
         end
         MODE_DELETE: begin
            if (pos == 0 || pos > held || pos - 1 + run > held) begin
               owe(STAT_BAD_POS, 0, '0, 1'b1);
            end else begin
               for (i = pos - 1; i + run < held; i++) list_mem[i] = list_mem[i+run];
               held -= run;
               owe(STAT_OK, 0, '0, 1'b1);
            end
         end
         MODE_FIND: begin
            hit = 0;
            for (i = 0; i < held && hit == 0; i++) if (list_mem[i] == v) hit = i + 1;
            if (hit != 0) owe(STAT_OK, hit, '0, 1'b1);
            else owe(STAT_NONE, 0, '0, 1'b1);
         end
         MODE_READ: begin
            if (held == 0) owe(STAT_NONE, 0, '0, 1'b1);
            else for (i = 0; i < held; i++) owe(STAT_OK, 0, list_mem[i], i + 1 == held);
         end
         MODE_CLEAR: begin
            held = 0;
            owe(STAT_OK, 0, '0, 1'b1);
         end
         default: begin
            owe(STAT_BAD_POS, 0, '0, 1'b1);
         end
      endcase
   endtask

   // compare result beats first, then take in a newly accepted command
   always @(posedge clock) begin
      if (reset) begin
         owed_beats.delete();
         held = 0;
      end else begin
         if (rsp_strobe) begin
            got_beat = {rsp_status, rsp_found_position, rsp_read_value, rsp_element_count,
                        rsp_last};
            beats_checked++;
            if (owed_beats.size() == 0) begin
               $error("result beat with nothing expected: status %0d count %0d",
                      rsp_status, rsp_element_count);
               fail_count++;
            end else begin
               want_beat = owed_beats.pop_front();
               if (got_beat.status !== want_beat.status) begin
                  $error("status: expected %0d, got %0d", want_beat.status, got_beat.status);
                  fail_count++;
               end
               if (got_beat.found !== want_beat.found) begin
                  $error("found_position: expected %0d, got %0d", want_beat.found,
                         got_beat.found);
                  fail_count++;
               end
               if (got_beat.value !== want_beat.value) begin
                  $error("read_value: expected %0d, got %0d", want_beat.value, got_beat.value);
                  fail_count++;
               end
               if (got_beat.count !== want_beat.count) begin
                  $error("element_count: expected %0d, got %0d", want_beat.count,
                         got_beat.count);
                  fail_count++;
               end
               if (got_beat.last !== want_beat.last) begin
                  $error("last: expected %0d, got %0d", want_beat.last, got_beat.last);
                  fail_count++;
               end
            end
         end
         if (start && !busy)
            predict_list_op(req_mode, int'(req_position), int'(req_run_length),
                            req_item_value);
      end
      outstanding = owed_beats.size();
   end

endmodule

/* tb/testbench.sv */
// top of the positional list buffer testbench: clock, reset, command stimulus and verdict
// depends on plb_pkg, positional_list_buffer and list_checker
`timescale 1ns / 100ps

module testbench;
   import plb_pkg::*;

   localparam int DEPTH     = DEPTH_DEF;
   localparam int ITEMS     = 410;
   localparam int QUIET_AT  = 350;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic [MODE_W-1:0] req_mode = '0;
   logic [POS_W-1:0]  req_position = '0;
   logic [POS_W-1:0]  req_run_length = '0;
   logic [VAL_W-1:0]  req_item_value = '0;
   wire               busy;
   wire               rsp_strobe;
   wire [STAT_W-1:0]  rsp_status;
   wire [POS_W-1:0]   rsp_found_position;
   wire [VAL_W-1:0]   rsp_read_value;
   wire [POS_W-1:0]   rsp_element_count;
   wire               rsp_last;

   int fail_count;
   int outstanding;
   int held;
   int beats_checked;
   int full_seen;
   int sent = 0;
   int guard;
   bit quiet = 1'b0;

   always #5 clock = ~clock;

   positional_list_buffer #(.DEPTH(DEPTH)) i_dut (
      .clock, .reset, .start, .busy,
      .req_mode, .req_position, .req_run_length, .req_item_value,
      .rsp_strobe, .rsp_status, .rsp_found_position, .rsp_read_value,
      .rsp_element_count, .rsp_last
   );

   list_checker #(.DEPTH(DEPTH)) i_checker (
      .clock, .reset, .start, .busy,
      .req_mode, .req_position, .req_run_length, .req_item_value,
      .rsp_strobe, .rsp_status, .rsp_found_position, .rsp_read_value,
      .rsp_element_count, .rsp_last,
      .fail_count, .outstanding, .held, .beats_checked, .full_seen
   );

   // present one command at a falling edge and hold it until busy lets it through
   task automatic issue(input logic [MODE_W-1:0] m, input int p, input int r, input int v);
      req_mode       <= m;
      req_position   <= POS_W'(p);
      req_run_length <= POS_W'(r);
      req_item_value <= VAL_W'(v);
      start          <= 1'b1;
      while (busy) @(negedge clock);
      @(negedge clock);
      sent++;
   endtask

   // sender gap with junk on the fields
   task automatic rest(input int n);
      start          <= 1'b0;
      req_mode       <= MODE_W'($urandom);
      req_position   <= POS_W'($urandom);
      req_run_length <= POS_W'($urandom);
      req_item_value <= VAL_W'($urandom);
      repeat (n) @(negedge clock);
   endtask

   task automatic maybe_rest();
      if (!quiet && $urandom_range(0, 3) == 0) rest($urandom_range(1, 13));
   endtask

   // hold off until every expected beat has arrived
   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (outstanding != 0 || busy) @(negedge clock);
   endtask

   // small values mostly, so that find hits often
   function automatic int pick_value();
      return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 11);
   endfunction

   // one random command shaped by the current list length
   task automatic random_cmd();
      int pick;
      int p;
      int r;
      int span;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         if ($urandom_range(0, 9) == 0) p = $urandom_range(0, 127);
         else if ($urandom_range(0, 4) == 0) p = ($urandom_range(0, 1) != 0) ? 1 : held + 1;
         else p = $urandom_range(1, held + 1);
         issue(MODE_INSERT, p, $urandom_range(0, 127), pick_value());
      end else if (pick < 60) begin
         if (held == 0 || $urandom_range(0, 6) == 0) begin
            p = $urandom_range(0, 127);
            r = $urandom_range(0, 127);
         end else begin
            p    = $urandom_range(1, held);
            span = held - p + 1;
            r    = ($urandom_range(0, 3) == 0) ? span
                   : $urandom_range(0, (span < 3) ? span : 3);
         end
         issue(MODE_DELETE, p, r, $urandom_range(0, 127));
      end else if (pick < 78) begin
         issue(MODE_FIND, $urandom_range(0, 127), $urandom_range(0, 127), pick_value());
      end else if (pick < 88) begin
         issue(MODE_READ, $urandom_range(0, 127), $urandom_range(0, 127),
               $urandom_range(0, 127));
      end else if (pick < 94) begin
         issue(MODE_CLEAR, $urandom_range(0, 127), $urandom_range(0, 127),
               $urandom_range(0, 127));
      end else begin
         issue(MODE_W'($urandom_range(5, 7)), $urandom_range(0, 127),
               $urandom_range(0, 127), $urandom_range(0, 127));
      end
   endtask

   // random mixed traffic up to a running total
   task automatic mixed_until(input int total);
      while (sent < total) begin
         quiet = (sent >= QUIET_AT);
         random_cmd();
         maybe_rest();
      end
   endtask

   // grow the list to full, push against the limit, then search it and read it all back
   task automatic fill_list();
      while (held < DEPTH) begin
         issue(MODE_INSERT, $urandom_range(1, held + 1), 0, pick_value());
         maybe_rest();
      end
      issue(MODE_INSERT, DEPTH + 1, 0, 7);
      issue(MODE_INSERT, 1, 0, 8);
      issue(MODE_INSERT, DEPTH + 2, 0, 9);
      issue(MODE_FIND, 0, 0, pick_value());
      maybe_rest();
      issue(MODE_READ, 0, 0, 0);
      maybe_rest();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty list, edge positions, every mode
      issue(MODE_READ, 0, 0, 0);
      issue(MODE_FIND, 0, 0, 42);
      issue(MODE_DELETE, 1, 0, 0);
      issue(MODE_INSERT, 0, 0, 1);
      issue(MODE_INSERT, 2, 0, 1);
      issue(MODE_INSERT, 1, 0, 127);
      issue(MODE_INSERT, 2, 0, 0);
      issue(MODE_INSERT, 1, 0, 99);
      issue(MODE_INSERT, 2, 0, 5);
      issue(MODE_FIND, 0, 0, 127);
      issue(MODE_FIND, 0, 0, 42);
      issue(MODE_FIND, 0, 0, 99);
      issue(MODE_DELETE, 1, 0, 0);
      issue(MODE_DELETE, 2, 2, 0);
      issue(MODE_DELETE, 1, 3, 0);
      issue(MODE_DELETE, 3, 0, 0);
      issue(MODE_DELETE, 127, 127, 127);
      issue(MODE_READ, 0, 0, 0);
      issue(3'd5, 1, 1, 1);
      issue(3'd6, 0, 0, 0);
      issue(3'd7, 127, 127, 127);
      issue(MODE_DELETE, 1, 2, 0);
      issue(MODE_INSERT, 1, 0, 64);
      issue(MODE_CLEAR, 0, 0, 0);
      issue(MODE_READ, 0, 0, 0);
      drain();

      // random part with two full-list passes and a mid-run drain
      mixed_until(120);
      fill_list();
      mixed_until(250);
      drain();
      fill_list();
      mixed_until(ITEMS);

      // wait out the last beats
      start <= 1'b0;
      guard = 0;
      while (outstanding != 0 && guard < 20000) begin
         @(negedge clock);
         guard++;
      end
      repeat (80) @(negedge clock);
      if (outstanding != 0) $error("%0d result beats never arrived", outstanding);

      $display("covered %0d commands and %0d result beats; inserts into a full list: %0d",
               sent, beats_checked, full_seen);
      if (fail_count == 0 && outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5000000;
      $display("status: fail");
      $finish;
   end

endmodule
